[sv/osfr_pkg.sv]
// Shared constants and types of the optical serial frame receiver.
`timescale 1ns / 1ps

package osfr_pkg;

   // Number of bytes that one frame can hold.
   localparam int unsigned BUFFER_DEPTH = 64;
   localparam int unsigned ADDR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int unsigned INDEX_W = $clog2(BUFFER_DEPTH + 1);

   localparam int unsigned HALF_W  = 8;
   localparam int unsigned GAP_W   = 4;
   localparam int unsigned TICK_W  = 9;
   localparam int unsigned PHASE_W = 4;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BIT_TICKS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_BIT_PERIODS = 1'd1;

   localparam logic [HALF_W-1:0] HALF_BIT_TICKS_RESET  = 8'd60;
   localparam logic [GAP_W-1:0]  GAP_BIT_PERIODS_RESET = 4'd3;

   localparam logic [PHASE_W-1:0] PHASE_START_CHECK = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_STOP        = 4'd10;
   localparam logic [PHASE_W-1:0] PHASE_MAX         = 4'd15;
   localparam logic [GAP_W-1:0]   GAP_MAX           = 4'd15;

   // Write port of the frame buffer.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } buf_write_type;

   // One result of the step logic.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              overflow;
   } result_type;

   // Frame status seen by the top level.
   typedef struct packed {
      logic               draining;
      logic [INDEX_W-1:0] wr_index;
      logic [INDEX_W-1:0] rd_index;
   } status_type;

endpackage

[sv/osfr_frame_buffer.sv]
// Frame byte store with one write port and one registered read port.
`timescale 1ns / 1ps

module osfr_frame_buffer
   import osfr_pkg::*;
(
   input  logic              clock,
   input  buf_write_type     wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // A write to the address being read is passed straight through.
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/osfr_rx_state.sv]
// Receiver state registers and the per-tick step logic.
`timescale 1ns / 1ps

module osfr_rx_state
   import osfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              line_level,
   input  logic              sink_ready,
   input  logic [HALF_W-1:0] half_bit_ticks,
   input  logic [GAP_W-1:0]  gap_bit_periods,
   output result_type        result,
   output status_type        status
);

   logic [PHASE_W-1:0] bit_phase_ff,  bit_phase_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [BYTE_W-1:0]  shift_reg_ff,  shift_reg_in;
   logic               byte_good_ff,  byte_good_in;
   logic [GAP_W-1:0]   gap_count_ff,  gap_count_in;
   logic               active_ff,     active_in;
   logic               armed_ff,      armed_in;
   logic               prev_level_ff, prev_level_in;
   logic [INDEX_W-1:0] wr_index_ff,   wr_index_in;
   logic [INDEX_W-1:0] rd_index_ff,   rd_index_in;
   logic               draining_ff,   draining_in;
   logic               overflow_ff,   overflow_in;

   buf_write_type     buf_wr;
   logic [BYTE_W-1:0] buf_rd_data;

   osfr_frame_buffer u_buffer (
      .clock   (clock),
      .wr      (buf_wr),
      .rd_addr (rd_index_in[ADDR_W-1:0]),
      .rd_data (buf_rd_data)
   );

   // The buffer output always holds the entry at the current read index.
   always_comb begin
      logic [TICK_W-1:0]  tick_next;
      logic [PHASE_W-1:0] phase_next;
      logic [GAP_W-1:0]   gap_next;

      bit_phase_in  = bit_phase_ff;
      tick_count_in = tick_count_ff;
      shift_reg_in  = shift_reg_ff;
      byte_good_in  = byte_good_ff;
      gap_count_in  = gap_count_ff;
      active_in     = active_ff;
      armed_in      = armed_ff;
      prev_level_in = prev_level_ff;
      wr_index_in   = wr_index_ff;
      rd_index_in   = rd_index_ff;
      draining_in   = draining_ff;
      overflow_in   = overflow_ff;
      result        = '0;
      buf_wr        = '0;
      tick_next     = tick_count_ff + 1'b1;
      phase_next    = bit_phase_ff;
      gap_next      = gap_count_ff;

      // Drain first.
      if (draining_ff && sink_ready) begin
         if (rd_index_ff < wr_index_ff) begin
            result.valid    = 1'b1;
            result.data     = buf_rd_data;
            result.last     = ((rd_index_ff + 1'b1) == wr_index_ff);
            result.overflow = overflow_ff;
            rd_index_in     = rd_index_ff + 1'b1;
         end else begin
            draining_in   = 1'b0;
            wr_index_in   = '0;
            rd_index_in   = '0;
            shift_reg_in  = '0;
            bit_phase_in  = '0;
            tick_count_in = '0;
            overflow_in   = 1'b0;
            armed_in      = 1'b1;
         end
      end

      // Then start edge detection, then bit timing.
      if (!draining_in && armed_in && prev_level_ff && !line_level) begin
         armed_in      = 1'b0;
         byte_good_in  = 1'b1;
         tick_count_in = '0;
         shift_reg_in  = '0;
         gap_count_in  = '0;
         bit_phase_in  = '0;
         active_in     = 1'b1;
      end else if (active_ff) begin
         if (bit_phase_ff == '0) begin
            if (tick_next >= {1'b0, half_bit_ticks}) begin
               tick_count_in = '0;
               bit_phase_in  = PHASE_START_CHECK;
               if (!line_level) begin
                  byte_good_in = 1'b0;
               end
            end else begin
               tick_count_in = tick_next;
            end
         end else if (tick_next < {half_bit_ticks, 1'b0}) begin
            tick_count_in = tick_next;
         end else begin
            tick_count_in = '0;
            if (bit_phase_ff < PHASE_MAX) begin
               phase_next = bit_phase_ff + 1'b1;
            end
            bit_phase_in = phase_next;
            if (phase_next >= PHASE_STOP) begin
               // Stop sample and the gap periods after it.
               if (phase_next == PHASE_STOP) begin
                  if (!line_level) begin
                     byte_good_in = 1'b0;
                  end
                  armed_in = 1'b1;
               end
               if (byte_good_in) begin
                  if (wr_index_ff < INDEX_W'(BUFFER_DEPTH)) begin
                     buf_wr.en   = 1'b1;
                     buf_wr.addr = wr_index_ff[ADDR_W-1:0];
                     buf_wr.data = shift_reg_ff;
                     wr_index_in = wr_index_ff + 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
                  byte_good_in = 1'b0;
               end
               if (gap_count_ff < GAP_MAX) begin
                  gap_next = gap_count_ff + 1'b1;
               end
               gap_count_in = gap_next;
               if (gap_next >= gap_bit_periods) begin
                  active_in     = 1'b0;
                  armed_in      = 1'b0;
                  bit_phase_in  = '0;
                  tick_count_in = '0;
                  rd_index_in   = '0;
                  draining_in   = 1'b1;
               end
            end else if (phase_next > PHASE_START_CHECK) begin
               shift_reg_in = {shift_reg_ff[BYTE_W-2:0], line_level};
            end
         end
      end

      prev_level_in = line_level;

      // Hold everything while no tick is being processed.
      if (!advance) begin
         bit_phase_in  = bit_phase_ff;
         tick_count_in = tick_count_ff;
         shift_reg_in  = shift_reg_ff;
         byte_good_in  = byte_good_ff;
         gap_count_in  = gap_count_ff;
         active_in     = active_ff;
         armed_in      = armed_ff;
         prev_level_in = prev_level_ff;
         wr_index_in   = wr_index_ff;
         rd_index_in   = rd_index_ff;
         draining_in   = draining_ff;
         overflow_in   = overflow_ff;
         buf_wr.en     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_phase_ff  <= '0;
         tick_count_ff <= '0;
         shift_reg_ff  <= '0;
         byte_good_ff  <= 1'b1;
         gap_count_ff  <= '0;
         active_ff     <= 1'b0;
         armed_ff      <= 1'b1;
         prev_level_ff <= 1'b1;
         wr_index_ff   <= '0;
         rd_index_ff   <= '0;
         draining_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
      end else begin
         bit_phase_ff  <= bit_phase_in;
         tick_count_ff <= tick_count_in;
         shift_reg_ff  <= shift_reg_in;
         byte_good_ff  <= byte_good_in;
         gap_count_ff  <= gap_count_in;
         active_ff     <= active_in;
         armed_ff      <= armed_in;
         prev_level_ff <= prev_level_in;
         wr_index_ff   <= wr_index_in;
         rd_index_ff   <= rd_index_in;
         draining_ff   <= draining_in;
         overflow_ff   <= overflow_in;
      end
   end

   assign status.draining = draining_ff;
   assign status.wr_index = wr_index_ff;
   assign status.rd_index = rd_index_ff;

endmodule

[sv/optical_serial_frame_receiver_unit.sv]
// Top level of the optical serial frame receiver.
`timescale 1ns / 1ps

// Each request carries one sampling tick of the receive line (line_level) and
// the downstream ready flag for that tick (sink_ready). The block accepts one
// request in every clock cycle while req_stall is low; a request is held in an
// input register, the receiver state and the frame buffer are updated by one
// pass of step logic, and any drained byte lands in a result register. That
// result register is the only place where the two sides meet: while a result
// waits under rsp_stall the next request can still be taken, and req_stall
// rises only when the input register is full and the result register cannot be
// freed. The 64-entry frame buffer is a memory with a registered read port
// whose address is driven from the next read index, so draining also runs at
// one byte per ready tick. The buffer needs no clearing pass after reset: only
// entries that were written in the current frame are ever read. The two
// configuration registers, half_bit_ticks (index 0) and gap_bit_periods
// (index 1), are always ready and should be written only while no request is
// in flight.
module optical_serial_frame_receiver_unit
   import osfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_line_level,
   input  logic                   req_sink_ready,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_out_last,
   output logic                   rsp_frame_overflow,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   logic [HALF_W-1:0] half_bit_ticks_ff;
   logic [GAP_W-1:0]  gap_bit_periods_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ticks_ff  <= HALF_BIT_TICKS_RESET;
         gap_bit_periods_ff <= GAP_BIT_PERIODS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_BIT_TICKS:  half_bit_ticks_ff  <= csr_data[HALF_W-1:0];
            CSR_GAP_BIT_PERIODS: gap_bit_periods_ff <= csr_data[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register. The step logic runs when the input register holds a
   // request and the result register is empty or being emptied.
   logic       in_valid_ff;
   logic       in_level_ff;
   logic       in_ready_ff;
   logic       out_free;
   logic       advance;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_level_ff <= req_line_level;
         in_ready_ff <= req_sink_ready;
      end
   end

   result_type result;
   status_type status;

   osfr_rx_state u_state (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .line_level      (in_level_ff),
      .sink_ready      (in_ready_ff),
      .half_bit_ticks  (half_bit_ticks_ff),
      .gap_bit_periods (gap_bit_periods_ff),
      .result          (result),
      .status          (status)
   );

   // Result register.
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;
   logic              out_overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_byte_ff     <= result.data;
         out_last_ff     <= result.last;
         out_overflow_ff <= result.overflow;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_out_last       = out_last_ff;
   assign rsp_frame_overflow = out_overflow_ff;

   // The drain never passes the fill point of the frame buffer.
   a_read_behind_write: assert property (@(posedge clock) disable iff (reset)
      status.rd_index <= status.wr_index)
      else $error("read index passed write index");

   // The fill point never goes beyond the buffer depth.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      status.wr_index <= INDEX_W'(BUFFER_DEPTH))
      else $error("write index beyond buffer depth");

   // A drained byte only comes out of a frame that is draining.
   a_result_while_draining: assert property (@(posedge clock) disable iff (reset)
      advance && result.valid |-> status.draining)
      else $error("result produced outside of draining");

   // A produced byte shows up in the result register on the next cycle.
   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      advance && result.valid |=> rsp_valid && (rsp_out_last == $past(result.last)))
      else $error("produced result not presented");

   // Requests are held back only while a finished result is stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

endmodule
